### design/sdi12lt_pkg.sv
// Shared types, codes and constants for the SDI-12 line transceiver.
package sdi12lt_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_RECV  = 2'd2;

    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_LF       = 2'd1;
    localparam logic [1:0] ST_TIMEOUT  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [2:0] CFG_BIT_TICKS     = 3'd0;
    localparam logic [2:0] CFG_BREAK_TICKS   = 3'd1;
    localparam logic [2:0] CFG_MARKING_TICKS = 3'd2;
    localparam logic [2:0] CFG_TIMEOUT_TICKS = 3'd3;
    localparam logic [2:0] CFG_MAX_CHARS     = 3'd4;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [3:0] FRAME_LAST = 4'd9;
    localparam logic [6:0] LINE_FEED  = 7'd10;

    typedef struct packed {
        logic [1:0] op;
        logic       line_in;
        logic [6:0] tx_char;
        logic       tx_first;
        logic       tx_last;
    } t_in_word;

    typedef struct packed {
        logic       line_out;
        logic       drive_enable;
        logic       tx_ready;
        logic       rejected;
        logic [6:0] rx_char;
        logic       rx_valid;
        logic [1:0] rx_status;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  bit_ticks;
        logic [15:0] break_ticks;
        logic [15:0] marking_ticks;
        logic [15:0] timeout_ticks;
        logic [5:0]  max_chars;
    } t_cfg;

    typedef enum logic [6:0] {
        MD_IDLE   = 7'b0000001,
        MD_BREAK  = 7'b0000010,
        MD_MARK   = 7'b0000100,
        MD_TXBIT  = 7'b0001000,
        MD_TXWAIT = 7'b0010000,
        MD_RXWAIT = 7'b0100000,
        MD_RXBIT  = 7'b1000000
    } t_mode;

endpackage

### design/sdi12lt_cfg.sv
// Configuration register file for the SDI-12 line transceiver.
module sdi12lt_cfg
    import sdi12lt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_ticks     <= 8'd16;
            r_cfg.break_ticks   <= 16'd250;
            r_cfg.marking_ticks <= 16'd160;
            r_cfg.timeout_ticks <= 16'd298;
            r_cfg.max_chars     <= 6'd19;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BIT_TICKS:     r_cfg.bit_ticks     <= i_cfg_data[7:0];
                CFG_BREAK_TICKS:   r_cfg.break_ticks   <= i_cfg_data;
                CFG_MARKING_TICKS: r_cfg.marking_ticks <= i_cfg_data;
                CFG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= i_cfg_data;
                CFG_MAX_CHARS:     r_cfg.max_chars     <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

endmodule

### design/sdi12lt_engine.sv
// Line state machine: one step per word, returns the result word for that step.
module sdi12lt_engine
    import sdi12lt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_word  i_word,
    input  t_cfg      i_cfg,
    output t_out_word o_result
);

    t_mode       r_mode, n_mode;
    logic [15:0] r_tick, n_tick;
    logic [3:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_last, n_last;

    logic [16:0] tick_inc;
    logic [7:0]  rx_target;
    logic [7:0]  rx_shift;
    logic [2:0]  rx_pos;
    logic [2:0]  tx_pos;
    logic        rejected;
    logic        rx_valid;
    logic [6:0]  rx_char;
    logic [1:0]  rx_status;
    logic        drive;
    logic        level;

    assign tick_inc  = {1'b0, r_tick} + 17'd1;
    assign rx_target = (r_bit == 4'd0) ? {1'b0, i_cfg.bit_ticks[7:1]} : i_cfg.bit_ticks;
    assign rx_pos    = r_bit[2:0] - 3'd1;

    always_comb begin
        n_mode    = r_mode;
        n_tick    = r_tick;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_cnt     = r_cnt;
        n_last    = r_last;
        rejected  = 1'b0;
        rx_valid  = 1'b0;
        rx_char   = 7'd0;
        rx_status = ST_NONE;
        rx_shift  = r_shift;

        case (i_word.op)
            OP_LOAD: begin
                if (r_mode == MD_IDLE || r_mode == MD_TXWAIT) begin
                    n_shift = {^i_word.tx_char, i_word.tx_char};
                    n_last  = i_word.tx_last;
                    n_tick  = 16'd0;
                    n_bit   = 4'd0;
                    n_mode  = i_word.tx_first ? MD_BREAK : MD_TXBIT;
                end else begin
                    rejected = 1'b1;
                end
            end
            OP_RECV: begin
                if (r_mode == MD_IDLE) begin
                    n_mode  = MD_RXWAIT;
                    n_tick  = 16'd0;
                    n_bit   = 4'd0;
                    n_shift = 8'd0;
                    n_cnt   = 6'd0;
                end else begin
                    rejected = 1'b1;
                end
            end
            OP_TICK: begin
                unique case (r_mode)
                    MD_BREAK: begin
                        n_tick = tick_inc[15:0];
                        if (tick_inc >= {1'b0, i_cfg.break_ticks}) begin
                            n_mode = MD_MARK;
                            n_tick = 16'd0;
                        end
                    end
                    MD_MARK: begin
                        n_tick = tick_inc[15:0];
                        if (tick_inc >= {1'b0, i_cfg.marking_ticks}) begin
                            n_mode = MD_TXBIT;
                            n_tick = 16'd0;
                            n_bit  = 4'd0;
                        end
                    end
                    MD_TXBIT: begin
                        n_tick = tick_inc[15:0];
                        if (tick_inc >= {9'd0, i_cfg.bit_ticks}) begin
                            n_tick = 16'd0;
                            if (r_bit >= FRAME_LAST) begin
                                n_bit  = 4'd0;
                                n_mode = r_last ? MD_IDLE : MD_TXWAIT;
                            end else begin
                                n_bit = r_bit + 4'd1;
                            end
                        end
                    end
                    MD_RXWAIT: begin
                        if (i_word.line_in) begin
                            // start bit seen: this tick is time zero of the character
                            n_mode  = MD_RXBIT;
                            n_tick  = 16'd0;
                            n_bit   = 4'd0;
                            n_shift = 8'd0;
                        end else begin
                            n_tick = tick_inc[15:0];
                            if (tick_inc >= {1'b0, i_cfg.timeout_ticks}) begin
                                n_mode    = MD_IDLE;
                                n_tick    = 16'd0;
                                rx_status = ST_TIMEOUT;
                            end
                        end
                    end
                    MD_RXBIT: begin
                        n_tick = tick_inc[15:0];
                        if (tick_inc >= {9'd0, rx_target}) begin
                            n_tick = 16'd0;
                            // raw low at a data bit center reads as one
                            if (r_bit >= 4'd1 && r_bit <= 4'd7 && !i_word.line_in) begin
                                rx_shift = r_shift | (8'd1 << rx_pos);
                            end
                            n_shift = rx_shift;
                            if (r_bit >= FRAME_LAST) begin
                                rx_char  = rx_shift[6:0];
                                rx_valid = 1'b1;
                                n_cnt    = r_cnt + 6'd1;
                                n_bit    = 4'd0;
                                n_shift  = 8'd0;
                                if (n_cnt >= i_cfg.max_chars) begin
                                    n_mode    = MD_IDLE;
                                    rx_status = ST_OVERFLOW;
                                end else if (rx_shift[6:0] == LINE_FEED) begin
                                    n_mode    = MD_IDLE;
                                    rx_status = ST_LF;
                                end else begin
                                    n_mode = MD_RXWAIT;
                                end
                            end else begin
                                n_bit = r_bit + 4'd1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Line level follows the state after this step.
    assign tx_pos = n_bit[2:0] - 3'd1;
    assign drive  = (n_mode == MD_BREAK) || (n_mode == MD_MARK) ||
                    (n_mode == MD_TXBIT) || (n_mode == MD_TXWAIT);

    always_comb begin
        level = 1'b0;
        if (n_mode == MD_BREAK) begin
            level = 1'b1;
        end else if (n_mode == MD_TXBIT) begin
            if (n_bit == 4'd0) begin
                level = 1'b1;
            end else if (n_bit <= 4'd8) begin
                level = ~n_shift[tx_pos];
            end
        end
    end

    always_comb begin
        o_result.line_out     = drive & level;
        o_result.drive_enable = drive;
        o_result.tx_ready     = (n_mode == MD_IDLE) || (n_mode == MD_TXWAIT);
        o_result.rejected     = rejected;
        o_result.rx_char      = rx_char;
        o_result.rx_valid     = rx_valid;
        o_result.rx_status    = rx_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MD_IDLE;
            r_tick  <= 16'd0;
            r_bit   <= 4'd0;
            r_shift <= 8'd0;
            r_cnt   <= 6'd0;
            r_last  <= 1'b0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
        end
    end

endmodule

### design/sdi12lt_stage.sv
// Input holding register and result register with valid/ready flow control.
module sdi12lt_stage
    import sdi12lt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out,
    output logic      o_fire,
    output t_in_word  o_word,
    input  t_out_word i_result
);

    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;
    logic      fire;

    // step the engine when a word is held and the result slot frees up
    assign fire        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || fire;
    assign o_fire      = fire;
    assign o_word      = r_in;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (fire) begin
            r_out <= i_result;
        end
    end

endmodule

### design/sdi12_line_transceiver_top.sv
// Top level of the SDI-12 line transceiver (7E1, inverted raw pin).
//
// Input channel (i_in_valid / o_in_ready / i_in): one word per tick or command.
// op 0 advances the line timing by one tick and samples line_in, op 1 loads a
// command character (break and marking first when tx_first is set), op 2 starts
// reception. Every accepted word yields exactly one result word on the output
// channel (o_out_valid / i_out_ready / o_out) with the pin drive, tx_ready,
// rejected flag, any received character and the end-of-response status.
// An accepted word waits in the input register until the result register is
// free, then the engine steps it and its result is registered. Throughput: one
// word per cycle while the receiver keeps i_out_ready high.
// When the receiver stalls, the result register holds and the input register
// fills; o_in_ready drops only once both are full, and nothing is lost.
// Configuration (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) is
// always ready and should be written only while no word is in flight.
// Reset (i_rst_n low, synchronous) returns to idle with the line released and
// loads the default timing registers; no clearing pass is needed.
module sdi12_line_transceiver_top
    import sdi12lt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_word               i_in,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_word              o_out,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg      cfg;
    logic      fire;
    t_in_word  word;
    t_out_word result;

    sdi12lt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sdi12lt_stage u_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .o_fire      (fire),
        .o_word      (word),
        .i_result    (result)
    );

    sdi12lt_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_word   (word),
        .i_cfg    (cfg),
        .o_result (result)
    );

endmodule

### bench/sdi12_line_transceiver_top_tb.sv
// Self-checking testbench for the SDI-12 line transceiver: driver, predictor and monitor.
module sdi12_line_transceiver_top_tb;
    import sdi12lt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned RANDOM_WORDS = 240;
    localparam int unsigned PHASE_WORDS = 60;
    localparam int unsigned IDLE_PCT = 38;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    t_in_word               i_in = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_out_word              o_out;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    sdi12_line_transceiver_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Line engine state as the predictor sees it
    t_mode       ln_mode = MD_IDLE;
    logic [15:0] ln_ticks = '0;
    logic [3:0]  ln_bit = '0;
    logic [7:0]  ln_shift = '0;
    logic [5:0]  ln_chars = '0;
    logic        ln_last = 1'b0;
    t_cfg        ln_cfg = '{bit_ticks: 8'd16, break_ticks: 16'd250, marking_ticks: 16'd160,
                            timeout_ticks: 16'd298, max_chars: 6'd19};

    t_in_word    pending_words[$];
    t_out_word   line_results_due[$];
    t_out_word   want;

    int unsigned tx_idle_pct = IDLE_PCT;
    int unsigned rx_idle_pct = IDLE_PCT;
    bit          tx_pause = 1'b0;
    int unsigned rx_hold_req = 0;
    int unsigned rx_hold_left = 0;
    bit          word_taken = 1'b0;
    int unsigned stall_cycles = 0;

    int unsigned words_queued = 0;
    int unsigned words_in = 0;
    int unsigned settings_used = 0;
    int unsigned rx_chars_seen = 0;
    int unsigned lf_ends = 0;
    int unsigned timeouts = 0;
    int unsigned overflows = 0;
    int unsigned rejects = 0;
    int unsigned err_count = 0;

    // Advance the line engine by one word and return the result word it gives
    function automatic t_out_word line_step(t_in_word w);
        t_out_word   r;
        int unsigned lim;
        logic        drive;
        r = '0;
        case (w.op)
            OP_LOAD: begin
                if (ln_mode == MD_IDLE || ln_mode == MD_TXWAIT) begin
                    ln_shift = {^w.tx_char, w.tx_char};
                    ln_last = w.tx_last;
                    ln_ticks = '0;
                    ln_bit = '0;
                    ln_mode = w.tx_first ? MD_BREAK : MD_TXBIT;
                end else begin
                    r.rejected = 1'b1;
                end
            end
            OP_RECV: begin
                if (ln_mode == MD_IDLE) begin
                    ln_mode = MD_RXWAIT;
                    ln_ticks = '0;
                    ln_bit = '0;
                    ln_shift = '0;
                    ln_chars = '0;
                end else begin
                    r.rejected = 1'b1;
                end
            end
            OP_TICK: begin
                case (ln_mode)
                    MD_BREAK: begin
                        ln_ticks = ln_ticks + 16'd1;
                        if (ln_ticks >= ln_cfg.break_ticks) begin
                            ln_mode = MD_MARK;
                            ln_ticks = '0;
                        end
                    end
                    MD_MARK: begin
                        ln_ticks = ln_ticks + 16'd1;
                        if (ln_ticks >= ln_cfg.marking_ticks) begin
                            ln_mode = MD_TXBIT;
                            ln_ticks = '0;
                            ln_bit = '0;
                        end
                    end
                    MD_TXBIT: begin
                        ln_ticks = ln_ticks + 16'd1;
                        if (ln_ticks >= ln_cfg.bit_ticks) begin
                            ln_ticks = '0;
                            if (ln_bit >= FRAME_LAST) begin
                                ln_bit = '0;
                                ln_mode = ln_last ? MD_IDLE : MD_TXWAIT;
                            end else begin
                                ln_bit = ln_bit + 4'd1;
                            end
                        end
                    end
                    MD_RXWAIT: begin
                        if (w.line_in) begin
                            ln_mode = MD_RXBIT;
                            ln_ticks = '0;
                            ln_bit = '0;
                            ln_shift = '0;
                        end else begin
                            ln_ticks = ln_ticks + 16'd1;
                            if (ln_ticks >= ln_cfg.timeout_ticks) begin
                                ln_mode = MD_IDLE;
                                ln_ticks = '0;
                                r.rx_status = ST_TIMEOUT;
                            end
                        end
                    end
                    MD_RXBIT: begin
                        ln_ticks = ln_ticks + 16'd1;
                        // first interval is the half bit up to the start bit center
                        lim = (ln_bit == 4'd0) ? (ln_cfg.bit_ticks >> 1) : ln_cfg.bit_ticks;
                        if (ln_ticks >= lim) begin
                            ln_ticks = '0;
                            if (ln_bit >= 4'd1 && ln_bit <= 4'd7 && !w.line_in)
                                ln_shift[ln_bit - 4'd1] = 1'b1;
                            if (ln_bit >= FRAME_LAST) begin
                                r.rx_char = ln_shift[6:0];
                                r.rx_valid = 1'b1;
                                ln_chars = ln_chars + 6'd1;
                                ln_bit = '0;
                                ln_shift = '0;
                                if (ln_chars >= ln_cfg.max_chars) begin
                                    ln_mode = MD_IDLE;
                                    r.rx_status = ST_OVERFLOW;
                                end else if (r.rx_char == LINE_FEED) begin
                                    ln_mode = MD_IDLE;
                                    r.rx_status = ST_LF;
                                end else begin
                                    ln_mode = MD_RXWAIT;
                                end
                            end else begin
                                ln_bit = ln_bit + 4'd1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        drive = (ln_mode == MD_BREAK || ln_mode == MD_MARK || ln_mode == MD_TXBIT ||
                 ln_mode == MD_TXWAIT);
        r.drive_enable = drive;
        if (ln_mode == MD_BREAK)
            r.line_out = 1'b1;
        else if (ln_mode == MD_TXBIT && ln_bit == 4'd0)
            r.line_out = 1'b1;
        else if (ln_mode == MD_TXBIT && ln_bit <= 4'd8)
            r.line_out = ~ln_shift[ln_bit - 4'd1];
        r.tx_ready = (ln_mode == MD_IDLE || ln_mode == MD_TXWAIT);
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            err_count++;
        end
    endfunction

    function automatic int unsigned at_least_one(int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic void push_word(logic [1:0] op, logic lvl, logic [6:0] ch, logic first,
                                      logic last);
        t_in_word w;
        w.op = op;
        w.line_in = lvl;
        w.tx_char = ch;
        w.tx_first = first;
        w.tx_last = last;
        pending_words.push_back(w);
        words_queued++;
    endfunction

    // scramble fills the fields that a tick ignores, and the line level, at random
    function automatic void push_ticks(int unsigned n, logic lvl, bit scramble);
        repeat (n) begin
            if (scramble)
                push_word(OP_TICK, 1'($urandom_range(1)), 7'($urandom_range(127)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                push_word(OP_TICK, lvl, '0, 1'b0, 1'b0);
        end
    endfunction

    // One 7E1 character on the raw pin: start high, a 1 bit low, stop low
    function automatic void queue_frame(logic [6:0] ch, int unsigned bt);
        logic [7:0] bits;
        int         k;
        bits = {^ch, ch};
        push_ticks(bt, 1'b1, 1'b0);
        for (k = 0; k < 8; k++)
            push_ticks(bt, ~bits[k], 1'b0);
        push_ticks(bt, 1'b0, 1'b0);
    endfunction

    function automatic void queue_command(int unsigned nchars);
        int unsigned i;
        int unsigned ticks;
        logic        first;
        logic        last;
        for (i = 0; i < nchars; i++) begin
            first = (i == 0) || ($urandom_range(7) == 0);
            last = (i == nchars - 1) && ($urandom_range(7) != 0);
            push_word(OP_LOAD, 1'($urandom_range(1)), 7'($urandom_range(127)), first, last);
            ticks = 10 * at_least_one(ln_cfg.bit_ticks);
            if (first)
                ticks += at_least_one(ln_cfg.break_ticks) + at_least_one(ln_cfg.marking_ticks);
            // cut the character short now and then, so the next load is refused
            if ($urandom_range(9) == 0)
                ticks = $urandom_range(ticks - 1);
            else
                ticks += $urandom_range(2);
            push_ticks(ticks, 1'b0, 1'b1);
        end
    endfunction

    function automatic void queue_response(int unsigned nchars, bit lf_end);
        int unsigned i;
        int unsigned bt;
        int unsigned tmo;
        int          room;
        logic [6:0]  ch;
        bt = at_least_one(ln_cfg.bit_ticks);
        tmo = at_least_one(ln_cfg.timeout_ticks);
        // keep the low time between characters inside the start bit wait
        room = int'(tmo) - (int'(bt) - int'(bt / 2) - 1) - 1;
        if (room < 0)
            room = 0;
        if (room > 3)
            room = 3;
        push_word(OP_RECV, 1'b0, 7'($urandom_range(127)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
        for (i = 0; i < nchars; i++) begin
            push_ticks($urandom_range(room), 1'b0, 1'b0);
            ch = (lf_end && i == nchars - 1) ? LINE_FEED : 7'($urandom_range(127));
            queue_frame(ch, bt);
        end
        // still waiting without a line feed: run out the timeout
        push_ticks(tmo + 1, 1'b0, 1'b0);
    endfunction

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(int unsigned bt, int unsigned brk, int unsigned mark,
                              int unsigned tmo, int unsigned maxc);
        write_reg(CFG_BIT_TICKS, bt);
        write_reg(CFG_BREAK_TICKS, brk);
        write_reg(CFG_MARKING_TICKS, mark);
        write_reg(CFG_TIMEOUT_TICKS, tmo);
        write_reg(CFG_MAX_CHARS, maxc);
        settings_used++;
    endtask

    // Wait out all words, then feed ticks or a closing character until the line is idle
    task automatic drain_to_idle();
        forever begin
            while (pending_words.size() != 0 || i_in_valid || line_results_due.size() != 0)
                @(posedge i_clk);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            if (ln_mode == MD_IDLE)
                break;
            if (ln_mode == MD_TXWAIT)
                push_word(OP_LOAD, 1'b0, 7'($urandom_range(127)), 1'b0, 1'b1);
            else
                push_ticks(32, 1'b0, 1'b0);
        end
    endtask

    // Sender: take the word at the edge, offer the next one at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            line_results_due.push_back(line_step(i_in));
            word_taken = 1'b1;
            words_in++;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (word_taken || !i_in_valid)) begin
            word_taken = 1'b0;
            if (pending_words.size() != 0 && !tx_pause && $urandom_range(99) >= tx_idle_pct) begin
                i_in <= pending_words.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Register writes update the predictor at the same edge as the block
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BIT_TICKS:     ln_cfg.bit_ticks = i_cfg_data[7:0];
                CFG_BREAK_TICKS:   ln_cfg.break_ticks = i_cfg_data;
                CFG_MARKING_TICKS: ln_cfg.marking_ticks = i_cfg_data;
                CFG_TIMEOUT_TICKS: ln_cfg.timeout_ticks = i_cfg_data;
                CFG_MAX_CHARS:     ln_cfg.max_chars = i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Receiver: compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (line_results_due.size() == 0) begin
                $error("result word arrived with no prediction waiting");
                err_count++;
            end else begin
                want = line_results_due.pop_front();
                check_field("line_out", want.line_out, o_out.line_out);
                check_field("drive_enable", want.drive_enable, o_out.drive_enable);
                check_field("tx_ready", want.tx_ready, o_out.tx_ready);
                check_field("rejected", want.rejected, o_out.rejected);
                check_field("rx_char", want.rx_char, o_out.rx_char);
                check_field("rx_valid", want.rx_valid, o_out.rx_valid);
                check_field("rx_status", want.rx_status, o_out.rx_status);
                rx_chars_seen += want.rx_valid;
                rejects += want.rejected;
                case (want.rx_status)
                    ST_LF:       lf_ends++;
                    ST_TIMEOUT:  timeouts++;
                    ST_OVERFLOW: overflows++;
                    default: ;
                endcase
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("sdi12_line_transceiver_top_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        int unsigned ph;
        int unsigned start_words;
        int unsigned phase_start;
        int unsigned bt;
        int unsigned tmo;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: busy refusals, break-less start, fresh break, end cases of a response
        set_config(4, 3, 2, 12, 3);
        push_word(OP_UNUSED, 1'b1, 7'h7F, 1'b1, 1'b1);
        push_word(OP_TICK, 1'b1, 7'h00, 1'b0, 1'b0);
        push_word(OP_LOAD, 1'b0, 7'h7F, 1'b0, 1'b0);
        push_word(OP_LOAD, 1'b0, 7'h55, 1'b1, 1'b1);
        push_word(OP_RECV, 1'b0, 7'h00, 1'b0, 1'b0);
        push_ticks(40, 1'b1, 1'b0);
        push_word(OP_RECV, 1'b0, 7'h00, 1'b0, 1'b0);
        push_word(OP_LOAD, 1'b0, 7'h00, 1'b1, 1'b1);
        push_ticks(45, 1'b0, 1'b0);
        push_word(OP_RECV, 1'b0, 7'h00, 1'b0, 1'b0);
        queue_frame(7'h41, 4);
        queue_frame(LINE_FEED, 4);
        push_word(OP_RECV, 1'b0, 7'h00, 1'b0, 1'b0);
        push_word(OP_RECV, 1'b0, 7'h00, 1'b0, 1'b0);
        queue_frame(7'h31, 4);
        queue_frame(7'h32, 4);
        queue_frame(LINE_FEED, 4);
        // start bit lands on the tick where the wait would run out
        push_word(OP_RECV, 1'b0, 7'h00, 1'b0, 1'b0);
        push_ticks(11, 1'b0, 1'b0);
        queue_frame(LINE_FEED, 4);
        push_word(OP_RECV, 1'b0, 7'h00, 1'b0, 1'b0);
        push_ticks(12, 1'b0, 1'b0);
        drain_to_idle();

        // Zero and one registers
        set_config(0, 0, 0, 0, 0);
        queue_command(2);
        queue_response(2, 1'b1);
        queue_response(1, 1'b0);
        drain_to_idle();
        set_config(1, 1, 1, 6, 2);
        queue_command(3);
        queue_response(3, 1'b1);
        queue_response(2, 1'b0);
        drain_to_idle();

        // Random phases, mostly well-formed commands and responses
        ph = 0;
        start_words = words_queued;
        while (words_queued - start_words < RANDOM_WORDS || ph < 4) begin
            if (ph == 0) begin
                set_config(2, 1, 1, 1, 1);
            end else begin
                bt = ($urandom_range(4) == 0) ? $urandom_range(6, 12) : $urandom_range(2, 5);
                tmo = ($urandom_range(4) == 0) ? $urandom_range(1, bt + 2)
                                               : bt + $urandom_range(4, 25);
                set_config(bt, $urandom_range(1, 10), $urandom_range(1, 10), tmo,
                           $urandom_range(1, 6));
            end
            phase_start = words_queued;
            while (words_queued - phase_start < PHASE_WORDS) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: queue_command($urandom_range(1, 4));
                    4, 5, 6, 7: queue_response($urandom_range(1, ln_cfg.max_chars + 1),
                                               1'($urandom_range(1)));
                    8: begin
                        repeat ($urandom_range(1, 6))
                            push_word(2'($urandom_range(3)), 1'($urandom_range(1)),
                                      7'($urandom_range(127)), 1'($urandom_range(1)),
                                      1'($urandom_range(1)));
                    end
                    default: begin
                        // garbled response: random line levels
                        push_word(OP_RECV, 1'b0, 7'h00, 1'b0, 1'b0);
                        push_ticks($urandom_range(20, 60), 1'b0, 1'b1);
                    end
                endcase
            end
            // hold off the result side long enough to back up the input
            if (ph == 1)
                rx_hold_req = 400;
            if (ph == 2) begin
                while (pending_words.size() > 40) @(posedge i_clk);
                tx_pause = 1'b1;
                while (line_results_due.size() != 0 || i_in_valid) @(posedge i_clk);
                tx_pause = 1'b0;
            end
            drain_to_idle();
            ph++;
        end

        // Widest character limit, one full command and response, with no idling
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_config(4, 20, 12, 30, 63);
        push_word(OP_LOAD, 1'b0, 7'h2A, 1'b1, 1'b1);
        push_ticks(20 + 12 + 10 * 4, 1'b0, 1'b1);
        push_word(OP_RECV, 1'b0, 7'h00, 1'b0, 1'b0);
        push_ticks(5, 1'b0, 1'b0);
        queue_frame(7'h30, 4);
        queue_frame(LINE_FEED, 4);
        drain_to_idle();
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;

        $display("Run: %0d words over %0d register settings, %0d refused as busy",
                 words_in, settings_used, rejects);
        $display("Received %0d characters; responses ended %0d on LF, %0d by timeout, %0d by overflow",
                 rx_chars_seen, lf_ends, timeouts, overflows);
        if (err_count == 0)
            $display("sdi12_line_transceiver_top_tb: PASS");
        else
            $display("sdi12_line_transceiver_top_tb: FAIL");
        $finish;
    end

endmodule

### files.f
design/sdi12lt_pkg.sv
design/sdi12lt_cfg.sv
design/sdi12lt_engine.sv
design/sdi12lt_stage.sv
design/sdi12_line_transceiver_top.sv
bench/sdi12_line_transceiver_top_tb.sv
